// File: hw/rtl/snge_pkg.sv
// Shared types, constants and codes of the spectral noise and gain estimator.
package snge_pkg;

    localparam int CHANNELS     = 8;
    localparam int FRAME_LENGTH = 512;
    localparam int PSLEN        = FRAME_LENGTH / 2 + 1;
    localparam int DEPTH        = CHANNELS * PSLEN;
    localparam int ADDR_W       = $clog2(DEPTH);

    localparam int CH_W   = 3;
    localparam int BIN_W  = 9;
    localparam int OBIN_W = 8;
    localparam int PW     = 40;
    localparam int CNT_W  = 16;
    localparam int GAIN_W = 16;
    localparam int EXT_W  = PW + 2;
    localparam int ACC_W  = 58;
    localparam int COEF_W = 17;
    localparam int HALF_W = PW / 2;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // divider: remainder, divisor, quotient and step count widths
    localparam int DIV_RW = EXT_W + 1;
    localparam int DIV_DW = EXT_W;
    localparam int QUO_W  = 17;
    localparam int STEP_W = 5;

    localparam logic [15:0] DECAY_RST  = 16'd26214;
    localparam logic [15:0] LEVEL_RST  = 16'd13107;
    localparam logic [7:0]  MINWIN_RST = 8'd150;
    localparam logic [7:0]  WARM_RST   = 8'd100;

    localparam logic [COEF_W-1:0] Q16_ONE   = 17'h10000;
    localparam logic [COEF_W-1:0] W_OLD     = 17'd45875;
    localparam logic [COEF_W-1:0] W_NEW     = 17'd19661;
    localparam logic [COEF_W-1:0] GAMMA     = 17'd9830;
    localparam logic [COEF_W-1:0] ADAPT_MIN = 17'd3277;
    localparam logic [ACC_W-1:0]  ACC_ROUND = 58'd32768;
    localparam logic [PW-1:0]     ONE_P     = 40'd256;

    typedef enum logic [1:0] {
        REG_DECAY  = 2'd0,
        REG_LEVEL  = 2'd1,
        REG_MINWIN = 2'd2,
        REG_WARM   = 2'd3
    } t_reg_idx;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_READ, S_PA, S_MAC, S_CAP, S_SMW, S_SF, S_MIN,
        S_DIVA, S_COND, S_POST, S_DIVG, S_DIVW, S_WB, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_PA, OP_NZ, OP_NUM, OP_SP1, OP_SP2, OP_COEF, OP_RV
    } t_mac_op;

    typedef struct packed {
        logic [PW-1:0] rmin;
        logic [PW-1:0] wmin;
        logic [PW-1:0] nz;
        logic [PW-1:0] rv;
        logic [PW-1:0] sp;
    } t_bin_state;

    typedef struct packed {
        logic              start;
        logic              lead;
        logic [STEP_W-1:0] steps;
        logic [DIV_RW-1:0] rem0;
        logic [DIV_DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic [QUO_W-1:0] quot;
    } t_div_rsp;

endpackage

// File: hw/rtl/snge_if.sv
// Valid/ready stream interfaces for bin powers in and gains out.
interface snge_in_if import snge_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  channel;
    logic [BIN_W-1:0] bin_index;
    logic [PW-1:0]    power;
    logic [CNT_W-1:0] frame_index;

    modport source(output valid, channel, bin_index, power, frame_index, input ready);
    modport sink(input valid, channel, bin_index, power, frame_index, output ready);
endinterface

interface snge_out_if import snge_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   out_channel;
    logic [OBIN_W-1:0] out_bin;
    logic [GAIN_W-1:0] gain;
    logic [PW-1:0]     noise_level;
    logic              frame_end;

    modport source(output valid, out_channel, out_bin, gain, noise_level, frame_end,
                   input ready);
    modport sink(input valid, out_channel, out_bin, gain, noise_level, frame_end,
                 output ready);
endinterface

// File: hw/rtl/snge_div.sv
// Restoring divider, one quotient bit per cycle.
module snge_div import snge_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic [STEP_W-1:0] r_left;
    logic              r_lead;
    logic [DIV_RW-1:0] r_rem;
    logic [DIV_DW-1:0] r_dvs;
    logic [QUO_W-1:0]  r_quo;

    logic [DIV_RW-1:0] shifted;
    logic              fits;
    logic [DIV_RW-1:0] n_rem;
    logic [QUO_W-1:0]  n_quo;

    always_comb begin
        // lead injects the single set dividend bit on the first step
        shifted = {r_rem[DIV_RW-2:0], r_lead};
        fits    = shifted >= {1'b0, r_dvs};
        n_rem   = fits ? shifted - {1'b0, r_dvs} : shifted;
        n_quo   = {r_quo[QUO_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_left <= i_req.steps;
        end else if (r_busy) begin
            r_left <= r_left - STEP_W'(1);
            if (r_left == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.rem0;
            r_dvs  <= i_req.divisor;
            r_quo  <= '0;
            r_lead <= i_req.lead;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_lead <= 1'b0;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.quot = r_quo;

endmodule

// File: hw/rtl/spectral_noise_gain_estimator_top.sv
// Top level: minima-controlled noise tracking and spectral gain per bin.
//
//  channel   dir  handshake                 carries
//  i_item    in   valid/ready               channel, bin, power, frame count
//  o_result  out  valid/ready               channel, bin, gain, noise, frame end
//  APB       in   psel/penable/pwrite       decay, level, min window, warmup
//
// One item at a time: each weighted sum runs on the shared 17x20 multiply-accumulate
// and each quotient on the shared 1-bit-per-cycle divider (17 quotient bits for the
// adapt rate, 16 for the gain). Bins 0 and 1 give no result. After reset a pass
// over all 2056 store entries zeroes the per-bin stores; i_item.ready stays low
// meanwhile. A finished result waits in an output register, so the next item is
// taken while o_result is stalled.
module spectral_noise_gain_estimator_top import snge_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    snge_in_if.sink            i_item,
    snge_out_if.source         o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    function automatic logic [PW-1:0] sat_pw(input logic [EXT_W-1:0] v);
        return (|v[EXT_W-1:PW]) ? '1 : v[PW-1:0];
    endfunction

    function automatic logic [ACC_W-1:0] mac_init(input t_mac_op op);
        return (op == OP_SP1 || op == OP_SP2) ? '0 : ACC_ROUND;
    endfunction

    // configuration
    logic [15:0] r_decay, r_level;
    logic [7:0]  r_minwin, r_warm;

    // control
    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_clr;
    t_mac_op           r_op, n_op;
    logic [1:0]        r_mstep, n_mstep;
    logic              r_o_valid, n_o_valid;
    logic [7:0]        r_phase, n_phase;
    logic [PW-1:0]     r_nw0, r_nw1, r_nw2, n_nw0, n_nw1, n_nw2;

    // item and working registers
    logic [CH_W-1:0]   r_ch, n_ch;
    logic [BIN_W-1:0]  r_bin, n_bin;
    logic [PW-1:0]     r_pw, n_pw;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [PW-1:0]     r_t, n_t;
    logic [PW-1:0]     r_pa, n_pa;
    logic [PW-1:0]     r_p2, r_p1, r_mag, n_p2, n_p1, n_mag;
    logic [PW-1:0]     r_sf, n_sf;
    logic [PW-1:0]     r_rmin, r_wmin, n_rmin, n_wmin;
    logic [COEF_W-1:0] r_adapt, n_adapt;
    logic [PW-1:0]     r_nz, n_nz;
    logic [PW-1:0]     r_post, n_post;
    logic [EXT_W-1:0]  r_den, n_den;
    logic [PW-1:0]     r_num, n_num;
    logic [GAIN_W-1:0] r_gain, n_gain;
    logic [PW-1:0]     r_sp, n_sp;
    logic [COEF_W-1:0] r_coef, n_coef;
    logic [PW-1:0]     r_rv, n_rv;

    logic [CH_W-1:0]   r_o_ch;
    logic [OBIN_W-1:0] r_o_bin;
    logic [GAIN_W-1:0] r_o_gain;
    logic [PW-1:0]     r_o_nz;
    logic              r_o_last;

    // memories
    logic [PW-1:0]     r_smem [DEPTH];
    t_bin_state        r_stmem [DEPTH];
    logic [PW-1:0]     r_sm_q;
    t_bin_state        r_st_q;
    logic              sm_we, st_we, rd_en;
    logic [ADDR_W-1:0] sm_waddr, st_waddr, prev_idx;
    logic [PW-1:0]     sm_wdata;
    t_bin_state        st_wdata;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic              in_take, in_range, out_free, last_bin, adapt_cond, out_load;
    logic [COEF_W-1:0] mac_coef;
    logic [PW-1:0]     mac_opnd;
    logic [HALF_W-1:0] mac_half;
    logic [COEF_W+HALF_W-1:0] mac_prod;
    logic [ACC_W-1:0]  mac_add;
    logic [PW-1:0]     mac_res;
    logic [EXT_W-1:0]  sf_sum, rmin3;
    logic [PW-1:0]     post1;
    logic [BIN_W-1:0]  obin;
    logic [8:0]        phase_nxt;

    assign i_item.ready = (r_state == S_IDLE);
    assign in_take  = i_item.valid && (r_state == S_IDLE);
    assign in_range = (32'(i_item.channel) < CHANNELS) && (32'(i_item.bin_index) < PSLEN);
    assign out_free = !r_o_valid || o_result.ready;
    assign last_bin = (32'(r_ch) == CHANNELS - 1) && (32'(r_bin) == PSLEN - 1);
    assign prev_idx = r_idx - ADDR_W'(1);
    assign mac_res  = sat_pw(r_acc[ACC_W-1:16]);
    assign rmin3    = {2'b0, r_rmin} + {1'b0, r_rmin, 1'b0};
    assign adapt_cond = ({2'b0, r_sf} < rmin3) || (r_cnt < {8'b0, r_warm})
                        || (r_st_q.nz > r_mag);
    assign sf_sum   = {2'b0, r_p2} + {1'b0, r_p1, 1'b0} + {2'b0, r_pa} + EXT_W'(2);
    assign post1    = (r_mag > r_nz) ? r_mag - r_nz : '0;
    assign obin     = r_bin - BIN_W'(1);
    assign phase_nxt = {1'b0, r_phase} + 9'd1;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay  <= DECAY_RST;
            r_level  <= LEVEL_RST;
            r_minwin <= MINWIN_RST;
            r_warm   <= WARM_RST;
        end else if (psel && penable && pwrite) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_DECAY:  r_decay  <= pwdata[15:0];
                REG_LEVEL:  r_level  <= pwdata[15:0];
                REG_MINWIN: r_minwin <= pwdata[7:0];
                REG_WARM:   r_warm   <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_DECAY:  prdata = {16'b0, r_decay};
            REG_LEVEL:  prdata = {16'b0, r_level};
            REG_MINWIN: prdata = {24'b0, r_minwin};
            REG_WARM:   prdata = {24'b0, r_warm};
        endcase
    end

    // multiply-accumulate operand select: steps 0/1 first term, 2/3 second term
    always_comb begin
        mac_coef = '0;
        mac_opnd = '0;
        case (r_op)
            OP_PA: begin
                mac_coef = r_mstep[1] ? W_NEW : W_OLD;
                mac_opnd = r_mstep[1] ? r_t : r_sm_q;
            end
            OP_NZ: begin
                mac_coef = r_mstep[1] ? r_adapt : Q16_ONE - r_adapt;
                mac_opnd = r_mstep[1] ? r_mag : r_st_q.nz;
            end
            OP_NUM: begin
                mac_coef = r_mstep[1] ? GAMMA : Q16_ONE - GAMMA;
                mac_opnd = r_mstep[1] ? r_post : r_st_q.sp;
            end
            OP_SP1: begin
                mac_coef = r_mstep[1] ? '0 : {1'b0, r_gain};
                mac_opnd = r_mag;
            end
            OP_SP2: begin
                mac_coef = r_mstep[1] ? '0 : {1'b0, r_gain};
                mac_opnd = r_t;
            end
            OP_COEF: begin
                mac_coef = r_mstep[1] ? '0 : Q16_ONE - {1'b0, r_decay};
                mac_opnd = {24'b0, r_level};
            end
            OP_RV: begin
                mac_coef = r_mstep[1] ? r_coef : {1'b0, r_decay};
                mac_opnd = r_mstep[1] ? r_sp : r_st_q.rv;
            end
            default: begin
                mac_coef = '0;
                mac_opnd = '0;
            end
        endcase
        mac_half = r_mstep[0] ? mac_opnd[PW-1:HALF_W] : mac_opnd[HALF_W-1:0];
        mac_prod = mac_coef * mac_half;
        mac_add  = r_mstep[0] ? ACC_W'({mac_prod, {HALF_W{1'b0}}}) : ACC_W'(mac_prod);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == ADDR_W'(DEPTH - 1)) n_state = S_IDLE;
            S_IDLE:  if (in_take && in_range) n_state = S_READ;
            S_READ:  n_state = S_PA;
            S_PA:    n_state = (r_bin == '0) ? S_SMW : S_MAC;
            S_MAC:   if (r_mstep == 2'd3) n_state = S_CAP;
            S_CAP: begin
                unique case (r_op)
                    OP_PA:   n_state = S_SMW;
                    OP_NZ:   n_state = S_POST;
                    OP_NUM:  n_state = S_DIVG;
                    OP_SP1:  n_state = S_MAC;
                    OP_SP2:  n_state = S_MAC;
                    OP_COEF: n_state = S_MAC;
                    OP_RV:   n_state = S_WB;
                endcase
            end
            S_SMW:   n_state = (r_bin < BIN_W'(2)) ? S_IDLE : S_SF;
            S_SF:    n_state = S_MIN;
            S_MIN:   n_state = S_DIVA;
            S_DIVA:  if (!div_rsp.busy) n_state = S_COND;
            S_COND:  n_state = adapt_cond ? S_MAC : S_POST;
            S_POST:  n_state = S_MAC;
            S_DIVG:  n_state = S_DIVW;
            S_DIVW:  if (!div_rsp.busy) n_state = S_MAC;
            S_WB:    n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
        endcase
    end

    // datapath and controls
    always_comb begin
        n_op = r_op;   n_mstep = r_mstep; n_acc = r_acc;
        n_ch = r_ch;   n_bin = r_bin;     n_pw = r_pw;   n_cnt = r_cnt; n_idx = r_idx;
        n_t = r_t;     n_pa = r_pa;       n_p2 = r_p2;   n_p1 = r_p1;   n_mag = r_mag;
        n_nw0 = r_nw0; n_nw1 = r_nw1;     n_nw2 = r_nw2; n_sf = r_sf;
        n_rmin = r_rmin; n_wmin = r_wmin; n_adapt = r_adapt; n_nz = r_nz;
        n_post = r_post; n_den = r_den;   n_num = r_num; n_gain = r_gain;
        n_sp = r_sp;   n_coef = r_coef;   n_rv = r_rv;   n_phase = r_phase;
        n_o_valid = r_o_valid && !o_result.ready;
        out_load = 1'b0;
        sm_we = 1'b0; sm_waddr = r_idx; sm_wdata = r_pa;
        st_we = 1'b0; st_waddr = prev_idx;
        st_wdata = '{rmin: r_rmin, wmin: r_wmin, nz: r_nz, rv: r_rv, sp: r_sp};
        rd_en = 1'b0;
        div_req = '{start: 1'b0, lead: 1'b0, steps: '0, rem0: '0, divisor: '0};

        unique case (r_state)
            S_CLEAR: begin
                sm_we = 1'b1; sm_waddr = r_clr; sm_wdata = '0;
                st_we = 1'b1; st_waddr = r_clr; st_wdata = '0;
            end
            S_IDLE: begin
                if (in_take) begin
                    n_ch  = i_item.channel;
                    n_bin = i_item.bin_index;
                    n_pw  = i_item.power;
                    n_cnt = i_item.frame_index;
                    n_idx = ADDR_W'(i_item.channel) * ADDR_W'(PSLEN)
                            + ADDR_W'(i_item.bin_index);
                end
            end
            S_READ: begin
                rd_en = 1'b1;
                n_t   = sat_pw({2'b0, r_pw} + {2'b0, ONE_P});
            end
            S_PA: begin
                if (r_bin == '0) begin
                    n_pa = '0;
                end else begin
                    n_op = OP_PA; n_mstep = '0; n_acc = mac_init(OP_PA);
                end
            end
            S_MAC: begin
                n_acc   = r_acc + mac_add;
                n_mstep = r_mstep + 2'd1;
            end
            S_CAP: begin
                unique case (r_op)
                    OP_PA:  n_pa  = mac_res;
                    OP_NZ:  n_nz  = mac_res;
                    OP_NUM: n_num = mac_res;
                    OP_SP1: begin
                        n_t = mac_res;
                        n_op = OP_SP2; n_mstep = '0; n_acc = mac_init(OP_SP2);
                    end
                    OP_SP2: begin
                        n_sp = mac_res;
                        n_op = OP_COEF; n_mstep = '0; n_acc = mac_init(OP_COEF);
                    end
                    OP_COEF: begin
                        n_coef = mac_res[COEF_W-1:0];
                        n_op = OP_RV; n_mstep = '0; n_acc = mac_init(OP_RV);
                    end
                    OP_RV:  n_rv = mac_res;
                endcase
            end
            S_SMW: begin
                sm_we = 1'b1;
                n_p2  = r_nw0; n_p1 = r_nw1; n_mag = r_nw2;
                n_nw0 = r_nw1; n_nw1 = r_pa; n_nw2 = r_pw;
            end
            S_SF: n_sf = sf_sum[EXT_W-1:2];
            S_MIN: begin
                // minimum restart on the first frame of each window
                if (r_phase == '0) begin
                    n_rmin = (r_st_q.wmin < r_sf) ? r_st_q.wmin : r_sf;
                    n_wmin = r_sf;
                end else begin
                    n_rmin = (r_st_q.rmin < r_sf) ? r_st_q.rmin : r_sf;
                    n_wmin = (r_st_q.wmin < r_sf) ? r_st_q.wmin : r_sf;
                end
                div_req = '{start: 1'b1, lead: 1'b1, steps: STEP_W'(QUO_W), rem0: '0,
                            divisor: DIV_DW'({1'b0, r_cnt} + 17'd1)};
            end
            S_DIVA: begin
                if (!div_rsp.busy) begin
                    n_adapt = (div_rsp.quot < ADAPT_MIN) ? ADAPT_MIN : div_rsp.quot;
                end
            end
            S_COND: begin
                if (adapt_cond) begin
                    n_op = OP_NZ; n_mstep = '0; n_acc = mac_init(OP_NZ);
                end else begin
                    n_nz = r_st_q.nz;
                end
            end
            S_POST: begin
                n_post = (post1 > r_st_q.rv) ? post1 - r_st_q.rv : '0;
                n_den  = {2'b0, ONE_P} + {2'b0, r_nz} + {2'b0, r_st_q.rv};
                n_op = OP_NUM; n_mstep = '0; n_acc = mac_init(OP_NUM);
            end
            S_DIVG: begin
                div_req = '{start: 1'b1, lead: 1'b0, steps: STEP_W'(GAIN_W),
                            rem0: DIV_RW'(r_num), divisor: {2'b0, r_num} + r_den};
            end
            S_DIVW: begin
                if (!div_rsp.busy) begin
                    n_gain = div_rsp.quot[GAIN_W-1:0];
                    n_op = OP_SP1; n_mstep = '0; n_acc = mac_init(OP_SP1);
                end
            end
            S_WB: begin
                st_we = 1'b1;
                if (last_bin) begin
                    n_phase = (phase_nxt >= {1'b0, r_minwin}) ? '0 : phase_nxt[7:0];
                end
            end
            S_OUT: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    n_o_valid = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_op      <= OP_PA;
            r_mstep   <= '0;
            r_o_valid <= 1'b0;
            r_phase   <= '0;
            r_nw0     <= '0;
            r_nw1     <= '0;
            r_nw2     <= '0;
        end else begin
            r_state   <= n_state;
            r_clr     <= (r_state == S_CLEAR) ? r_clr + ADDR_W'(1) : r_clr;
            r_op      <= n_op;
            r_mstep   <= n_mstep;
            r_o_valid <= n_o_valid;
            r_phase   <= n_phase;
            r_nw0     <= n_nw0;
            r_nw1     <= n_nw1;
            r_nw2     <= n_nw2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch <= n_ch;     r_bin <= n_bin;   r_pw <= n_pw;     r_cnt <= n_cnt;
        r_idx <= n_idx;   r_acc <= n_acc;   r_t <= n_t;       r_pa <= n_pa;
        r_p2 <= n_p2;     r_p1 <= n_p1;     r_mag <= n_mag;   r_sf <= n_sf;
        r_rmin <= n_rmin; r_wmin <= n_wmin; r_adapt <= n_adapt;
        r_nz <= n_nz;     r_post <= n_post; r_den <= n_den;   r_num <= n_num;
        r_gain <= n_gain; r_sp <= n_sp;     r_coef <= n_coef; r_rv <= n_rv;
        if (out_load) begin
            r_o_ch   <= r_ch;
            r_o_bin  <= obin[OBIN_W-1:0];
            r_o_gain <= r_gain;
            r_o_nz   <= r_nz;
            r_o_last <= last_bin;
        end
    end

    // per-bin stores: smoothed power at this bin, the rest at the finished bin
    always_ff @(posedge i_clk) begin
        if (sm_we) r_smem[sm_waddr] <= sm_wdata;
        if (rd_en) r_sm_q <= r_smem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (st_we) r_stmem[st_waddr] <= st_wdata;
        if (rd_en) r_st_q <= r_stmem[prev_idx];
    end

    snge_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_result.valid       = r_o_valid;
    assign o_result.out_channel = r_o_ch;
    assign o_result.out_bin     = r_o_bin;
    assign o_result.gain        = r_o_gain;
    assign o_result.noise_level = r_o_nz;
    assign o_result.frame_end   = r_o_last;

endmodule

// File: bench/tb_top.sv
// Testbench for the spectral noise and gain estimator: directed and random bins, predicted gains.
`timescale 1ns / 100ps
module tb_top import snge_pkg::*; ();

    typedef longint unsigned t_u64;

    typedef struct {
        bit [CH_W-1:0]   ch;
        bit [OBIN_W-1:0] bin;
        bit [GAIN_W-1:0] gain;
        bit [PW-1:0]     noise;
        bit              fend;
    } t_gain_result;

    class gain_scoreboard;
        t_u64 decay, level, minwin, warm;
        t_u64 smooth[DEPTH], rmin[DEPTH], wmin[DEPTH], noise[DEPTH], reverb[DEPTH], speech[DEPTH];
        t_u64 nbr[3];
        t_u64 phase;
        t_gain_result pending[$];
        int errors;

        function new();
            decay = t_u64'(DECAY_RST); level = t_u64'(LEVEL_RST);
            minwin = t_u64'(MINWIN_RST); warm = t_u64'(WARM_RST);
            foreach (smooth[i]) begin
                smooth[i] = 0; rmin[i] = 0; wmin[i] = 0;
                noise[i] = 0; reverb[i] = 0; speech[i] = 0;
            end
            nbr = '{0, 0, 0};
            phase = 0;
            errors = 0;
        endfunction

        function t_u64 sat(t_u64 v);
            return v > 64'hFF_FFFF_FFFF ? 64'hFF_FFFF_FFFF : v;
        endfunction

        function void set_reg(t_reg_idx r, t_u64 v);
            case (r)
                REG_DECAY:  decay  = v & 16'hFFFF;
                REG_LEVEL:  level  = v & 16'hFFFF;
                REG_MINWIN: minwin = v & 8'hFF;
                REG_WARM:   warm   = v & 8'hFF;
            endcase
        endfunction

        // accepted bin power: update the per-bin state, queue the finished previous bin
        function void note_input(bit [CH_W-1:0] ch, bit [BIN_W-1:0] bn, bit [PW-1:0] pw,
                                 bit [CNT_W-1:0] cnt);
            t_u64 idx, pa, p2, p1, mag, sf, adapt, nz, post, num, den, g, coef, nxt;
            t_gain_result r;
            if (ch >= CHANNELS || bn >= PSLEN) return;
            idx = t_u64'(ch) * PSLEN + bn;
            if (bn == 0) pa = 0;
            else pa = sat((64'd45875 * smooth[idx] + 64'd19661 * sat(t_u64'(pw) + 256)
                           + 32768) >> 16);
            smooth[idx] = pa;
            p2 = nbr[0]; p1 = nbr[1]; mag = nbr[2];
            nbr[0] = p1; nbr[1] = pa; nbr[2] = t_u64'(pw);
            if (bn < 2) return;
            idx = idx - 1;

            sf = (p2 + 2 * p1 + pa + 2) >> 2;
            if (phase == 0) begin
                rmin[idx] = wmin[idx] < sf ? wmin[idx] : sf;
                wmin[idx] = sf;
            end else begin
                rmin[idx] = rmin[idx] < sf ? rmin[idx] : sf;
                wmin[idx] = wmin[idx] < sf ? wmin[idx] : sf;
            end

            adapt = 65536 / (t_u64'(cnt) + 1);
            if (adapt < 3277) adapt = 3277;
            nz = noise[idx];
            if (sf < 3 * rmin[idx] || cnt < warm || nz > mag)
                nz = sat(((65536 - adapt) * nz + adapt * mag + 32768) >> 16);
            noise[idx] = nz;

            post = mag > nz ? mag - nz : 0;
            post = post > reverb[idx] ? post - reverb[idx] : 0;
            num = sat(((65536 - 9830) * speech[idx] + 9830 * post + 32768) >> 16);
            den = 256 + nz + reverb[idx];
            g = (num << 16) / (num + den);
            if (g > 16'hFFFF) g = 16'hFFFF;
            speech[idx] = sat((((mag * g) >> 16) * g) >> 16);
            coef = ((65536 - decay) * level + 32768) >> 16;
            reverb[idx] = sat((decay * reverb[idx] + coef * speech[idx] + 32768) >> 16);

            r.fend = (ch == CHANNELS - 1) && (bn == PSLEN - 1);
            if (r.fend) begin
                nxt = phase + 1;
                phase = (nxt >= minwin) ? 0 : (nxt & 8'hFF);
            end
            r.ch = ch; r.bin = OBIN_W'(bn - 1); r.gain = GAIN_W'(g); r.noise = PW'(nz);
            pending = {pending, r};
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check(t_gain_result got);
            t_gain_result e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result ch %0d bin %0d", got.ch, got.bin));
                return;
            end
            e = pending.pop_front();
            if (got.ch != e.ch) report($sformatf("channel %0d exp %0d", got.ch, e.ch));
            if (got.bin != e.bin) report($sformatf("bin %0d exp %0d", got.bin, e.bin));
            if (got.gain != e.gain)
                report($sformatf("bin %0d gain %0d exp %0d", e.bin, got.gain, e.gain));
            if (got.noise != e.noise)
                report($sformatf("bin %0d noise %0d exp %0d", e.bin, got.noise, e.noise));
            if (got.fend != e.fend)
                report($sformatf("bin %0d frame_end %0d exp %0d", e.bin, got.fend, e.fend));
        endtask
    endclass

    localparam int LIMIT = 1_500_000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    snge_in_if  in_bus();
    snge_out_if out_bus();

    spectral_noise_gain_estimator_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(in_bus), .o_result(out_bus),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    gain_scoreboard sb = new();
    int src_pct = 27, sink_pct = 59;
    bit hold_req = 0;
    int hold_left = 0;
    int unsigned cycles = 0;

    always #6 i_clk = ~i_clk;

    initial begin
        in_bus.valid = 0; in_bus.channel = '0; in_bus.bin_index = '0;
        in_bus.power = '0; in_bus.frame_index = '0;
        out_bus.ready = 0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            out_bus.ready <= 0;
            hold_left--;
        end else if (hold_req) begin
            hold_req = 0;
            hold_left = 600;
            out_bus.ready <= 0;
        end else begin
            out_bus.ready <= ($urandom_range(99) >= sink_pct);
        end
    end

    always @(posedge i_clk) begin
        t_gain_result g;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            g.ch = out_bus.out_channel; g.bin = out_bus.out_bin; g.gain = out_bus.gain;
            g.noise = out_bus.noise_level; g.fend = out_bus.frame_end;
            sb.check(g);
        end
    end

    task automatic send_bin(bit [CH_W-1:0] ch, bit [BIN_W-1:0] bn, bit [PW-1:0] pw,
                            bit [CNT_W-1:0] cnt);
        if ($urandom_range(99) < src_pct) begin
            in_bus.valid <= 0;
            do @(posedge i_clk); while ($urandom_range(99) < src_pct);
        end
        in_bus.valid <= 1;
        in_bus.channel <= ch; in_bus.bin_index <= bn;
        in_bus.power <= pw; in_bus.frame_index <= cnt;
        do @(posedge i_clk); while (!in_bus.ready);
        sb.note_input(ch, bn, pw, cnt);
    endtask

    task automatic apb_write(t_reg_idx r, bit [PDATA_W-1:0] v);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= PADDR_W'(r) << 2; pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge i_clk);
        sb.set_reg(r, t_u64'(v));
    endtask

    // drain everything, then allow a bin that yields nothing to finish
    task automatic drain();
        in_bus.valid <= 0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
        repeat (150) @(posedge i_clk);
    endtask

    function automatic bit [PW-1:0] pick_power();
        case ($urandom_range(9))
            0: return '0;
            1: return {PW{1'b1}};
            2, 3: return PW'({$urandom, $urandom});
            default: return PW'($urandom_range(200000));
        endcase
    endfunction

    function automatic bit [CNT_W-1:0] pick_count();
        case ($urandom_range(7))
            0: return 16'hFFFF;
            1: return CNT_W'($urandom);
            default: return CNT_W'($urandom_range(300));
        endcase
    endfunction

    task automatic random_bins(int n);
        int done = 0;
        int bn, len;
        bit [CH_W-1:0] ch;
        bit [CNT_W-1:0] cnt;
        while (done < n) begin
            if ($urandom_range(99) < 85) begin
                ch = CH_W'($urandom);
                cnt = pick_count();
                case ($urandom_range(3))
                    0: bn = 0;
                    1: bn = $urandom_range(256, 236);
                    default: bn = $urandom_range(256);
                endcase
                len = $urandom_range(20, 2);
                for (int k = 0; k < len && bn <= 256; k++) begin
                    send_bin(ch, BIN_W'(bn), pick_power(), cnt);
                    bn++;
                    done++;
                end
            end else begin
                bn = $urandom_range(511);
                send_bin(CH_W'($urandom), BIN_W'(bn), pick_power(), pick_count());
                if (bn < PSLEN) done++;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: edge bins, extreme powers and counts, ignored bins, frame end
        send_bin(0, 0, {PW{1'b1}}, 0);
        send_bin(0, 1, 0, 0);
        send_bin(0, 2, {PW{1'b1}}, 16'hFFFF);
        send_bin(0, 3, 0, 16'hFFFF);
        send_bin(0, 4, 40'h55_5555_5555, 1);
        send_bin(0, 5, 40'hAA_AAAA_AAAA, 100);
        send_bin(0, 300, {PW{1'b1}}, 5);
        send_bin(0, 511, {PW{1'b1}}, 16'hFFFF);
        send_bin(0, 6, 256, 99);
        send_bin(7, 254, {PW{1'b1}}, 1000);
        send_bin(7, 255, 0, 1000);
        send_bin(7, 256, {PW{1'b1}}, 1000);
        send_bin(7, 0, 1000, 1000);
        send_bin(7, 1, 1000, 1000);
        send_bin(7, 2, 1000, 1000);
        send_bin(3, 255, 12345, 0);
        send_bin(3, 256, 54321, 0);
        random_bins(140);
        drain();

        apb_write(REG_DECAY, 0);
        apb_write(REG_LEVEL, 65535);
        apb_write(REG_MINWIN, 1);
        apb_write(REG_WARM, 0);
        random_bins(150);
        drain();

        src_pct = 59; sink_pct = 27;
        apb_write(REG_DECAY, 65535);
        apb_write(REG_LEVEL, 0);
        apb_write(REG_MINWIN, 255);
        apb_write(REG_WARM, 255);
        random_bins(150);
        drain();

        apb_write(REG_DECAY, $urandom);
        apb_write(REG_LEVEL, $urandom);
        apb_write(REG_MINWIN, 2);
        apb_write(REG_WARM, 3);
        hold_req = 1;
        random_bins(150);
        drain();

        src_pct = 0; sink_pct = 0;
        apb_write(REG_DECAY, 26214);
        apb_write(REG_LEVEL, 13107);
        apb_write(REG_MINWIN, 3);
        apb_write(REG_WARM, 0);
        random_bins(150);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
